// ===== src/ltdq_pkg.sv =====
// ----------------------------------------------------------------------------
// ltdq_pkg
// Field widths, request kinds, status codes and the controller command type
// for the linked task deque.
// ----------------------------------------------------------------------------
package ltdq_pkg;

   localparam int KIND_W   = 3;
   localparam int TASK_W   = 6;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd3;

   // Work left for the finish step of a request.
   localparam logic [1:0] ACT_NONE       = 2'd0;
   localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
   localparam logic [1:0] ACT_PUSH_BACK  = 2'd2;
   localparam logic [1:0] ACT_DETACH     = 2'd3;

   typedef struct packed {
      logic load;     // capture the request fields
      logic exec;     // decide, write own links or read links
      logic commit;   // write neighbor links, update ends, load response
   } ltdq_cmd_type;

endpackage

// ===== src/ltdq_req_if.sv =====
// ----------------------------------------------------------------------------
// ltdq_req_if
// Request channel of the linked task deque: valid, ready and the request.
// ----------------------------------------------------------------------------
interface ltdq_req_if;
   import ltdq_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [TASK_W-1:0] task_id;

   modport source (output valid, output kind, output task_id, input ready);
   modport sink   (input valid, input kind, input task_id, output ready);
endinterface

// ===== src/ltdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ltdq_rsp_if
// Response channel of the linked task deque: valid, ready and the result.
// ----------------------------------------------------------------------------
interface ltdq_rsp_if;
   import ltdq_pkg::*;

   logic                valid;
   logic                ready;
   logic [TASK_W-1:0]   out_task;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output out_task, output status, input ready);
   modport sink   (input valid, input out_task, input status, output ready);
endinterface

// ===== src/ltdq_ram.sv =====
// ----------------------------------------------------------------------------
// ltdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ltdq_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/ltdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltdq_ctrl
// Request sequencer: idle, execute and finish states, plus the response
// valid flag.
// ----------------------------------------------------------------------------
module ltdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ltdq_pkg::ltdq_cmd_type cmd
);
   import ltdq_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       commit;
   logic       accept;

   // The finish step completes only when the response register is free.
   assign commit    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && ((state_ff == S_IDLE) || commit);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (commit) state_in = accept ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = accept;
   assign cmd.exec   = (state_ff == S_EXEC);
   assign cmd.commit = commit;
endmodule

// ===== src/ltdq_dpath.sv =====
// ----------------------------------------------------------------------------
// ltdq_dpath
// List datapath: link RAMs, membership bits, head and tail pointers, and the
// response register.
// ----------------------------------------------------------------------------
module ltdq_dpath #(
   parameter int NUM_TASKS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ltdq_pkg::ltdq_cmd_type            cmd,
   input  logic [ltdq_pkg::KIND_W-1:0]       req_kind,
   input  logic [ltdq_pkg::TASK_W-1:0]       req_task_id,
   output logic [ltdq_pkg::TASK_W-1:0]       rsp_out_task,
   output logic [ltdq_pkg::STATUS_W-1:0]     rsp_status
);
   import ltdq_pkg::*;

   localparam int IDX_W  = $clog2(NUM_TASKS);
   localparam int LINK_W = $clog2(NUM_TASKS + 1);
   localparam logic [LINK_W-1:0] SENT = LINK_W'(NUM_TASKS);

   logic [KIND_W-1:0]   kind_ff;
   logic [TASK_W-1:0]   task_ff;
   logic [1:0]          act_ff, act_in;
   logic [LINK_W-1:0]   x_ff, x_in;
   logic [LINK_W-1:0]   link_ff, link_in;
   logic [TASK_W-1:0]   res_task_ff, res_task_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [TASK_W-1:0]   rsp_task_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   tail_ff, tail_in;
   logic [NUM_TASKS-1:0] member_ff, member_in;

   logic [15:0]         task_wide;
   logic [LINK_W-1:0]   task_link;
   logic                task_valid;
   logic                task_member;
   logic [LINK_W-1:0]   pop_end;
   logic [15:0]         end_wide;

   logic                next_wr_en, prev_wr_en, link_rd_en;
   logic [IDX_W-1:0]    next_wr_addr, prev_wr_addr;
   logic [LINK_W-1:0]   next_wr_data, prev_wr_data;
   logic [LINK_W-1:0]   next_rd, prev_rd;

   assign task_wide   = {10'b0, task_ff};
   assign task_link   = task_wide[LINK_W-1:0];
   assign task_valid  = task_wide < 16'(NUM_TASKS);
   assign task_member = task_valid && member_ff[task_link[IDX_W-1:0]];
   assign pop_end     = (kind_ff == KIND_POP_FRONT) ? head_ff : tail_ff;
   assign end_wide    = {{(16-LINK_W){1'b0}}, pop_end};

   // Decision and first link access (execute), neighbor update (commit).
   always_comb begin
      act_in        = act_ff;
      x_in          = x_ff;
      link_in       = link_ff;
      res_task_in   = res_task_ff;
      res_status_in = res_status_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      member_in     = member_ff;
      next_wr_en    = 1'b0;
      next_wr_addr  = task_link[IDX_W-1:0];
      next_wr_data  = SENT;
      prev_wr_en    = 1'b0;
      prev_wr_addr  = task_link[IDX_W-1:0];
      prev_wr_data  = SENT;
      link_rd_en    = 1'b0;

      if (cmd.exec) begin
         act_in        = ACT_NONE;
         x_in          = task_link;
         link_in       = SENT;
         res_task_in   = task_ff;
         res_status_in = ST_DONE;
         case (kind_ff)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
               if (!task_valid) begin
                  res_status_in = ST_NOT_MEMBER;
               end else if (task_member) begin
                  res_status_in = ST_ALREADY;
               end else if (kind_ff == KIND_PUSH_FRONT) begin
                  act_in       = ACT_PUSH_FRONT;
                  link_in      = head_ff;
                  next_wr_en   = 1'b1;
                  next_wr_data = head_ff;
                  prev_wr_en   = 1'b1;
                  prev_wr_data = SENT;
               end else begin
                  act_in       = ACT_PUSH_BACK;
                  link_in      = tail_ff;
                  next_wr_en   = 1'b1;
                  next_wr_data = SENT;
                  prev_wr_en   = 1'b1;
                  prev_wr_data = tail_ff;
               end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
               if (pop_end >= SENT) begin
                  res_task_in   = '0;
                  res_status_in = ST_EMPTY;
               end else begin
                  act_in      = ACT_DETACH;
                  x_in        = pop_end;
                  res_task_in = end_wide[TASK_W-1:0];
                  link_rd_en  = 1'b1;
               end
            end
            KIND_REMOVE: begin
               if (!task_member) begin
                  res_status_in = ST_NOT_MEMBER;
               end else begin
                  act_in     = ACT_DETACH;
                  link_rd_en = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.commit) begin
         case (act_ff)
            ACT_PUSH_FRONT: begin
               if (link_ff < SENT) begin
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = link_ff[IDX_W-1:0];
                  prev_wr_data = x_ff;
               end else begin
                  tail_in = x_ff;
               end
               head_in = x_ff;
               member_in[x_ff[IDX_W-1:0]] = 1'b1;
            end
            ACT_PUSH_BACK: begin
               if (link_ff < SENT) begin
                  next_wr_en   = 1'b1;
                  next_wr_addr = link_ff[IDX_W-1:0];
                  next_wr_data = x_ff;
               end else begin
                  head_in = x_ff;
               end
               tail_in = x_ff;
               member_in[x_ff[IDX_W-1:0]] = 1'b1;
            end
            ACT_DETACH: begin
               // Splice the predecessor and successor of the slot together.
               if (prev_rd < SENT) begin
                  next_wr_en   = 1'b1;
                  next_wr_addr = prev_rd[IDX_W-1:0];
                  next_wr_data = next_rd;
               end else begin
                  head_in = next_rd;
               end
               if (next_rd < SENT) begin
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = next_rd[IDX_W-1:0];
                  prev_wr_data = prev_rd;
               end else begin
                  tail_in = prev_rd;
               end
               member_in[x_ff[IDX_W-1:0]] = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   ltdq_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_TASKS)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (x_in[IDX_W-1:0]),
      .rd_data (next_rd)
   );

   ltdq_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_TASKS)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (x_in[IDX_W-1:0]),
      .rd_data (prev_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= ACT_NONE;
         head_ff   <= SENT;
         tail_ff   <= SENT;
         member_ff <= '0;
      end else begin
         act_ff    <= act_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         member_ff <= member_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         task_ff <= req_task_id;
      end
      x_ff          <= x_in;
      link_ff       <= link_in;
      res_task_ff   <= res_task_in;
      res_status_ff <= res_status_in;
      if (cmd.commit) begin
         rsp_task_ff   <= res_task_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_out_task = rsp_task_ff;
   assign rsp_status   = rsp_status_ff;
endmodule

// ===== src/linked_task_deque_unit.sv =====
// ----------------------------------------------------------------------------
// linked_task_deque_unit
// Doubly linked list of task slots with push/pop at both ends and removal of
// a named slot.
//
//   channel  direction  payload                 handshake
//   req_ch   in         kind, task_id           valid/ready
//   rsp_ch   out        out_task, status        valid/ready
//
// Each request has an execute step that reads the slot's links (or writes
// the new slot's own links) and a finish step that writes the neighbors'
// links, since the link RAMs return registered read data.
// Reset clears the member bits and sets head and tail to the sentinel; the
// link RAMs are not cleared. A waiting response holds the finish step of
// the following request, not its acceptance.
// ----------------------------------------------------------------------------
module linked_task_deque_unit #(
   parameter int NUM_TASKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   ltdq_req_if.sink    req_ch,
   ltdq_rsp_if.source  rsp_ch
);
   import ltdq_pkg::*;

   ltdq_cmd_type cmd;

   ltdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   ltdq_dpath #(
      .NUM_TASKS (NUM_TASKS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_kind     (req_ch.kind),
      .req_task_id  (req_ch.task_id),
      .rsp_out_task (rsp_ch.out_task),
      .rsp_status   (rsp_ch.status)
   );
endmodule

// ===== src/ltdq_checker.sv =====
// ----------------------------------------------------------------------------
// ltdq_checker
// Port-level checks for the linked task deque, bound to the top level.
// ----------------------------------------------------------------------------
module ltdq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ltdq_pkg::TASK_W-1:0]     rsp_out_task,
   input logic [ltdq_pkg::STATUS_W-1:0]   rsp_status
);
   import ltdq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_task) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   // Every request spends an execute cycle in which no new request is taken.
   a_one_per_two: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   a_empty_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_out_task == '0))
      else $error("empty pop returned a nonzero task");
endmodule

bind linked_task_deque_unit ltdq_checker u_ltdq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_task (rsp_ch.out_task),
   .rsp_status   (rsp_ch.status)
);

// ===== dv/linked_task_deque_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_task_deque_unit_tb
// Self-checking bench for the linked task deque. Requests are pushes, pops,
// removals and unused kinds. The bench keeps its own copy of the list,
// predicts each response when its request is accepted, and checks the
// responses in order. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module linked_task_deque_unit_tb;
   import ltdq_pkg::*;

   localparam int               SLOTS          = 64;
   localparam logic [6:0]       LINK_END       = 7'd64;
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
   localparam int               WATCHDOG_LIMIT = 2000;
   localparam int               SETTLE_CYCLES  = 4;
   localparam int               MAX_REPORTS    = 10;

   typedef struct packed {
      logic [TASK_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } deque_rsp_type;

   logic clock = 1'b0;
   logic reset;

   ltdq_req_if req_ch ();
   ltdq_rsp_if rsp_ch ();

   linked_task_deque_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the list.
   logic [6:0] shadow_next [SLOTS];
   logic [6:0] shadow_prev [SLOTS];
   logic       shadow_member [SLOTS];
   logic [6:0] shadow_head;
   logic [6:0] shadow_tail;
   int         list_len;
   int         peak_len;

   deque_rsp_type pending_rsp [$];
   deque_rsp_type got_rsp;
   deque_rsp_type want_rsp;

   int mismatches;
   int rsp_checked;
   int idle_cycles;
   int req_gap_pct;
   int rsp_stall_pct;
   int n_push, n_pop, n_remove, n_spare;
   int n_empty, n_already, n_not_member;

   function automatic void unlink_slot(logic [TASK_W-1:0] s);
      logic [6:0] p;
      logic [6:0] n;
      p = shadow_prev[s];
      n = shadow_next[s];
      if (p != LINK_END) shadow_next[p[5:0]] = n;
      else shadow_head = n;
      if (n != LINK_END) shadow_prev[n[5:0]] = p;
      else shadow_tail = p;
      shadow_next[s]   = LINK_END;
      shadow_prev[s]   = LINK_END;
      shadow_member[s] = 1'b0;
      list_len--;
   endfunction

   // Applies one request to the shadow list and returns the response it owes.
   function automatic deque_rsp_type deque_apply(logic [KIND_W-1:0] kind,
                                                 logic [TASK_W-1:0] id);
      deque_rsp_type r;
      logic [6:0] end_slot;
      r.slot   = id;
      r.status = ST_DONE;
      case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            n_push++;
            if (shadow_member[id]) begin
               r.status = ST_ALREADY;
            end else if (kind == KIND_PUSH_FRONT) begin
               shadow_next[id]   = shadow_head;
               shadow_prev[id]   = LINK_END;
               shadow_member[id] = 1'b1;
               if (shadow_head != LINK_END) shadow_prev[shadow_head[5:0]] = {1'b0, id};
               else shadow_tail = {1'b0, id};
               shadow_head = {1'b0, id};
               list_len++;
            end else begin
               shadow_next[id]   = LINK_END;
               shadow_prev[id]   = shadow_tail;
               shadow_member[id] = 1'b1;
               if (shadow_tail != LINK_END) shadow_next[shadow_tail[5:0]] = {1'b0, id};
               else shadow_head = {1'b0, id};
               shadow_tail = {1'b0, id};
               list_len++;
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            n_pop++;
            end_slot = (kind == KIND_POP_FRONT) ? shadow_head : shadow_tail;
            if (end_slot == LINK_END) begin
               r.slot   = '0;
               r.status = ST_EMPTY;
            end else begin
               r.slot = end_slot[5:0];
               unlink_slot(end_slot[5:0]);
            end
         end
         KIND_REMOVE: begin
            n_remove++;
            if (!shadow_member[id]) r.status = ST_NOT_MEMBER;
            else unlink_slot(id);
         end
         default: n_spare++;
      endcase
      if (list_len > peak_len) peak_len = list_len;
      return r;
   endfunction

   // Returns a random slot that is (or is not) a member, if one exists.
   function automatic logic [TASK_W-1:0] pick_slot(bit want_member);
      int cnt;
      int k;
      cnt = 0;
      for (int i = 0; i < SLOTS; i++) if (shadow_member[i] == want_member) cnt++;
      if (cnt == 0) return TASK_W'($urandom_range(0, SLOTS - 1));
      k = $urandom_range(0, cnt - 1);
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_member[i] == want_member) begin
            if (k == 0) return TASK_W'(i);
            k--;
         end
      end
      return '0;
   endfunction

   task automatic send_request(logic [KIND_W-1:0] kind, logic [TASK_W-1:0] id);
      int gap;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.task_id <= id;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp = {pending_rsp, deque_apply(kind, id)};
   endtask

   // Lowers valid and waits until every predicted response has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random request; push_pct sets how strongly the list tends to grow.
   task automatic send_random_item(int push_pct);
      int r;
      int rest;
      logic [KIND_W-1:0] kind;
      logic [TASK_W-1:0] id;
      r    = $urandom_range(0, 99);
      rest = 95 - push_pct;
      id   = TASK_W'($urandom_range(0, SLOTS - 1));
      if (r < 5) begin
         kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end else if (r < 5 + push_pct) begin
         kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
         id   = pick_slot($urandom_range(0, 9) == 0);
      end else if (r < 5 + push_pct + rest * 6 / 10) begin
         kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      end else begin
         kind = KIND_REMOVE;
         id   = pick_slot($urandom_range(0, 9) != 0);
      end
      send_request(kind, id);
   endtask

   task automatic test_directed();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      send_request(KIND_POP_FRONT, 6'd17);
      send_request(KIND_POP_BACK, 6'd63);
      send_request(KIND_REMOVE, 6'd0);
      send_request(KIND_REMOVE, 6'd63);
      send_request(KIND_PUSH_FRONT, 6'd0);
      send_request(KIND_PUSH_FRONT, 6'd0);
      send_request(KIND_PUSH_BACK, 6'd63);
      send_request(KIND_PUSH_BACK, 6'd63);
      send_request(KIND_PUSH_FRONT, 6'd42);
      send_request(KIND_PUSH_BACK, 6'd21);
      // The list is now 42, 0, 63, 21: take out the middle, head and tail.
      send_request(KIND_REMOVE, 6'd0);
      send_request(KIND_REMOVE, 6'd42);
      send_request(KIND_REMOVE, 6'd21);
      send_request(KIND_REMOVE, 6'd21);
      send_request(KIND_POP_FRONT, 6'd0);
      send_request(KIND_POP_BACK, 6'd0);
      send_request(KIND_PUSH_BACK, 6'd5);
      send_request(KIND_POP_BACK, 6'd63);
      send_request(KIND_PUSH_FRONT, 6'd7);
      send_request(KIND_POP_FRONT, 6'd0);
      send_request(KIND_SPARE_LO, 6'd63);
      send_request(KIND_SPARE_MID, 6'd0);
      send_request(KIND_SPARE_HI, 6'd42);
      send_request(KIND_SPARE_HI, 6'd21);
      wait_drained();
   endtask

   // Fills every slot, pauses until all responses are back, then empties.
   task automatic test_full_list();
      int order [SLOTS];
      int j;
      int tmp;
      req_gap_pct   = 10;
      rsp_stall_pct = 10;
      for (int i = 0; i < SLOTS; i++) order[i] = i;
      for (int i = SLOTS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < SLOTS; i++)
         send_request(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT, TASK_W'(order[i]));
      wait_drained();
      send_request(KIND_PUSH_BACK, pick_slot(1'b1));
      send_request(KIND_PUSH_FRONT, pick_slot(1'b1));
      for (int i = 0; i < 8; i++) send_request(KIND_REMOVE, pick_slot(1'b1));
      while (list_len > 0)
         send_request($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT,
                      TASK_W'($urandom_range(0, SLOTS - 1)));
      send_request(KIND_POP_FRONT, 6'd63);
      send_request(KIND_REMOVE, pick_slot(1'b0));
   endtask

   task automatic test_random_mix(int segments);
      int push_pct;
      for (int s = 0; s < segments; s++) begin
         push_pct      = $urandom_range(15, 75);
         req_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         rsp_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         for (int i = 0; i < 100; i++) send_random_item(push_pct);
         if (s == segments / 2) wait_drained();
      end
   endtask

   task automatic test_back_to_back(int n_items);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < n_items; i++) send_random_item(50);
      wait_drained();
   endtask

   // Response side: ready drops in random bursts.
   initial begin : rsp_throttle
      int gap;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || $urandom_range(0, 99) >= rsp_stall_pct) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            gap = $urandom_range(1, 10);
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_rsp.slot   = rsp_ch.out_task;
         got_rsp.status = rsp_ch.status;
         rsp_checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with none expected: out_task %0d status %0d",
                        $realtime, got_rsp.slot, got_rsp.status);
         end else begin
            want_rsp = pending_rsp[0];
            pending_rsp.delete(0);
            if (got_rsp.slot != want_rsp.slot || got_rsp.status != want_rsp.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch: out_task exp %0d got %0d, status exp %0d got %0d",
                           $realtime, want_rsp.slot, got_rsp.slot,
                           want_rsp.status, got_rsp.status);
            end
            case (want_rsp.status)
               ST_EMPTY:      n_empty++;
               ST_ALREADY:    n_already++;
               ST_NOT_MEMBER: n_not_member++;
               default: ;
            endcase
         end
      end
   end

   // Ends the run when neither channel has moved a request for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d responses outstanding",
                  $realtime, WATCHDOG_LIMIT, pending_rsp.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= KIND_PUSH_FRONT;
      req_ch.task_id <= '0;
      reset          <= 1'b1;
      mismatches = 0;
      rsp_checked = 0;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      list_len = 0;
      peak_len = 0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_next[i]   = '0;
         shadow_prev[i]   = '0;
         shadow_member[i] = 1'b0;
      end
      shadow_head = LINK_END;
      shadow_tail = LINK_END;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_list();
      test_random_mix(16);
      test_back_to_back(150);

      $display("Covered %0d pushes, %0d pops, %0d removes, %0d unused kinds; %0d responses.",
               n_push, n_pop, n_remove, n_spare, rsp_checked);
      $display("Empty pops %0d, repeated pushes %0d, non-member removes %0d, longest list %0d.",
               n_empty, n_already, n_not_member, peak_len);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/ltdq_pkg.sv
src/ltdq_req_if.sv
src/ltdq_rsp_if.sv
src/ltdq_ram.sv
src/ltdq_ctrl.sv
src/ltdq_dpath.sv
src/linked_task_deque_unit.sv
src/ltdq_checker.sv
dv/linked_task_deque_unit_tb.sv
